>>> hw/rtl/segment_aabb_overlap_test_core_macros.svh
// Assertion macros for the segment versus box overlap core.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef SEGMENT_AABB_OVERLAP_TEST_CORE_MACROS_SVH
`define SEGMENT_AABB_OVERLAP_TEST_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SAABB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SAABB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/saabb_pkg.sv
// Shared widths, register codes and stage types of the segment/box overlap core.
// No dependencies.
package saabb_pkg;

    localparam int NUM_AXES   = 3;
    localparam int COORD_W    = 32;
    localparam int EXT_W      = 31;
    localparam int MARGIN_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 384;
    localparam int M_TDATA_W  = 8;

    // doubled-coordinate widths, sized so nothing wraps
    localparam int MID_W  = 35;  // twice midpoint minus twice box center
    localparam int DIR_W  = 33;  // finish - start
    localparam int PAD_W  = 34;  // |dir| + 2*margin
    localparam int PROD_W = 68;  // mid * dir
    localparam int RAD_W  = 65;  // extent * pad
    localparam int DIFF_W = 69;  // difference of two cross products

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X = 2'd0,
        CFG_OFFSET_Y = 2'd1,
        CFG_OFFSET_Z = 2'd2,
        CFG_MARGIN   = 2'd3
    } t_cfg_idx;

    // component pairs of the three cross axes: (y,z), (z,x), (x,y)
    localparam logic [1:0] CROSS_I [NUM_AXES] = '{2'd1, 2'd2, 2'd0};
    localparam logic [1:0] CROSS_J [NUM_AXES] = '{2'd2, 2'd0, 2'd1};

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [EXT_W-1:0]   t_ext;

    typedef struct packed {
        t_ext   [NUM_AXES-1:0] extent;
        t_coord [NUM_AXES-1:0] corner;
        t_coord [NUM_AXES-1:0] finish;
        t_coord [NUM_AXES-1:0] start;
    } t_item;

    typedef struct packed {
        logic                             world_sep;
        logic [NUM_AXES-1:0][PAD_W-1:0]   pad;
        t_ext [NUM_AXES-1:0]              extent;
        logic [NUM_AXES-1:0][DIR_W-1:0]   dir;
        logic [NUM_AXES-1:0][MID_W-1:0]   mid;
    } t_geom;

    typedef struct packed {
        logic                             world_sep;
        logic [NUM_AXES-1:0][PROD_W-1:0]  lhs_a;
        logic [NUM_AXES-1:0][PROD_W-1:0]  lhs_b;
        logic [NUM_AXES-1:0][RAD_W-1:0]   rhs_a;
        logic [NUM_AXES-1:0][RAD_W-1:0]   rhs_b;
    } t_prod;

endpackage

>>> hw/rtl/segment_aabb_overlap_test_core.sv
// Segment versus axis-aligned box overlap core (separating-axis test), Q16.16.
// Depends on saabb_pkg and segment_aabb_overlap_test_core_macros.svh.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+--------------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready | segment endpoints + box, 384 b
//  m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready | overlap flag, 8 b
//  cfg       | in        | i_cfg_valid/o_cfg_ready      | register index + 32 b data
//
// One item per cycle sustained while the output is not stalled. An accepted item loads
// the input register, then moves through the geometry stage, the multiplier stage and
// the result register, which drives o_m_axis_tvalid.
// The twelve 35x33-class multipliers in the third stage bound the clock.
// Reset (synchronous, active low) empties all stages and loads the register defaults.
// A stalled output holds its result; each stage takes a new item whenever it is empty
// or its successor moves, so bubbles are squeezed out and input stalls only when full.
`include "segment_aabb_overlap_test_core_macros.svh"

module segment_aabb_overlap_test_core
    import saabb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // from bit 0: start_x, start_y, start_z, finish_x, finish_y, finish_z,
    // box_corner_x, box_corner_y, box_corner_z (32 b each),
    // box_extent_x, box_extent_y, box_extent_z (31 b each), zero pad
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // from bit 0: overlap, zero pad
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ---------------------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------------------
    t_coord [NUM_AXES-1:0] r_offset;
    logic [MARGIN_W-1:0]   r_margin;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OFFSET_X: r_offset[0] <= i_cfg_data;
                CFG_OFFSET_Y: r_offset[1] <= i_cfg_data;
                CFG_OFFSET_Z: r_offset[2] <= i_cfg_data;
                CFG_MARGIN:   r_margin    <= i_cfg_data[MARGIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage flow control: a stage loads when empty or when its successor loads
    // ---------------------------------------------------------------------------------
    logic  r_in_valid, r_geom_valid, r_prod_valid, r_out_valid;
    logic  en_in, en_geom, en_prod, en_out;
    logic  s_accept;

    assign en_out   = !r_out_valid  || i_m_axis_tready;
    assign en_prod  = !r_prod_valid || en_out;
    assign en_geom  = !r_geom_valid || en_prod;
    assign en_in    = !r_in_valid   || en_geom;
    assign o_s_axis_tready = en_in;
    assign s_accept = i_s_axis_tvalid && en_in;

    // ---------------------------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------------------------
    t_item r_in;
    t_item n_in;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            n_in.start[k]  = i_s_axis_tdata[COORD_W*k +: COORD_W];
            n_in.finish[k] = i_s_axis_tdata[COORD_W*(NUM_AXES+k) +: COORD_W];
            n_in.corner[k] = i_s_axis_tdata[COORD_W*(2*NUM_AXES+k) +: COORD_W];
            n_in.extent[k] = i_s_axis_tdata[COORD_W*3*NUM_AXES + EXT_W*k +: EXT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en_in) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (s_accept) begin
            r_in <= n_in;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 2: doubled midpoint, direction, padded |dir|, world-axis test
    // ---------------------------------------------------------------------------------
    t_geom r_geom;
    t_geom n_geom;

    always_comb begin
        logic signed [MID_W-1:0] mid;
        logic signed [DIR_W-1:0] dir;
        logic [DIR_W-1:0]        dir_abs;
        logic [MID_W-1:0]        mid_abs;
        n_geom.world_sep = 1'b0;
        for (int k = 0; k < NUM_AXES; k++) begin
            mid = MID_W'($signed(r_in.start[k])) + MID_W'($signed(r_in.finish[k]))
                - (MID_W'($signed(r_offset[k])) <<< 1)
                - (MID_W'($signed(r_in.corner[k])) <<< 1)
                - $signed(MID_W'(r_in.extent[k]));
            dir = DIR_W'($signed(r_in.finish[k])) - DIR_W'($signed(r_in.start[k]));
            dir_abs = dir[DIR_W-1] ? DIR_W'(-dir) : DIR_W'(dir);
            mid_abs = mid[MID_W-1] ? MID_W'(-mid) : MID_W'(mid);
            // a strictly larger center distance separates; touching overlaps
            if (mid_abs > MID_W'(r_in.extent[k]) + MID_W'(dir_abs)) begin
                n_geom.world_sep = 1'b1;
            end
            n_geom.mid[k]    = mid;
            n_geom.dir[k]    = dir;
            n_geom.extent[k] = r_in.extent[k];
            n_geom.pad[k]    = PAD_W'(dir_abs) + PAD_W'({r_margin, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom_valid <= 1'b0;
        end else if (en_geom) begin
            r_geom_valid <= r_in_valid;
        end
        if (en_geom && r_in_valid) begin
            r_geom <= n_geom;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 3: cross-axis products, full width
    // ---------------------------------------------------------------------------------
    t_prod r_prod;
    t_prod n_prod;

    always_comb begin
        logic [1:0] ai;
        logic [1:0] aj;
        n_prod.world_sep = r_geom.world_sep;
        for (int k = 0; k < NUM_AXES; k++) begin
            ai = CROSS_I[k];
            aj = CROSS_J[k];
            n_prod.lhs_a[k] = PROD_W'($signed(r_geom.mid[ai])) * PROD_W'($signed(r_geom.dir[aj]));
            n_prod.lhs_b[k] = PROD_W'($signed(r_geom.mid[aj])) * PROD_W'($signed(r_geom.dir[ai]));
            n_prod.rhs_a[k] = RAD_W'(r_geom.extent[ai]) * RAD_W'(r_geom.pad[aj]);
            n_prod.rhs_b[k] = RAD_W'(r_geom.extent[aj]) * RAD_W'(r_geom.pad[ai]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (en_prod) begin
            r_prod_valid <= r_geom_valid;
        end
        if (en_prod && r_geom_valid) begin
            r_prod <= n_prod;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 4: cross-axis compare and result register
    // ---------------------------------------------------------------------------------
    logic r_out_overlap;
    logic n_out_overlap;

    always_comb begin
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] rsum;
        logic                     sep;
        sep = r_prod.world_sep;
        for (int k = 0; k < NUM_AXES; k++) begin
            diff = DIFF_W'($signed(r_prod.lhs_a[k])) - DIFF_W'($signed(r_prod.lhs_b[k]));
            rsum = $signed(DIFF_W'(r_prod.rhs_a[k]) + DIFF_W'(r_prod.rhs_b[k]));
            // |diff| > rsum, checked on both signs at once
            if ((diff > rsum) || (diff < -rsum)) begin
                sep = 1'b1;
            end
        end
        n_out_overlap = !sep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_prod_valid;
        end
        if (en_out && r_prod_valid) begin
            r_out_overlap <= n_out_overlap;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, r_out_overlap};

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
    `SAABB_ASSERT_NXT(a_accept_lands, s_accept, r_in_valid, "accepted item missing from input stage")
    `SAABB_ASSERT_NXT(a_world_sep_clears, r_prod_valid && r_prod.world_sep && en_out, !r_out_overlap, "world-axis separation reported as overlap")
    `SAABB_ASSERT_IMP(a_stall_only_full, !o_s_axis_tready, r_in_valid && r_geom_valid && r_prod_valid && r_out_valid && !i_m_axis_tready, "input stalled with a free stage")

endmodule

>>> sim/segment_aabb_overlap_test_core_test.sv
// Self-checking bench for segment_aabb_overlap_test_core: segment/box overlap items in,
// hit flags out, compared against a bit-exact predictor of the separating-axis test.
// Depends on saabb_pkg and the core RTL; needs no files or arguments.
module segment_aabb_overlap_test_core_test;
    import saabb_pkg::*;

    localparam int PIPE_LATENCY      = 4;
    localparam int RUN_LIMIT_CYCLES  = 400000;
    localparam int RESET_CYCLES      = 12;
    localparam int PROBE_ROWS        = 18;
    localparam int SETTINGS_COUNT    = 6;
    localparam int ITEMS_PER_SETTING = 190;
    localparam int IDLE_PCT          = 27;
    localparam int MISMATCH_SHOWN    = 10;

    // Q16.16 shorthands for the probe table
    localparam int ONE    = 32'h0001_0000;
    localparam int HALF   = 32'h0000_8000;
    localparam int I32_LO = 32'h8000_0000;
    localparam int I32_HI = 32'h7FFF_FFFF;
    localparam int EXT_HI = 32'h7FFF_FFFF;

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483647 - 64'sd1;

    // how a probe row gets its expected flag
    typedef enum logic [1:0] {
        ROW_SEPARATE,
        ROW_OVERLAP,
        ROW_PREDICT
    } t_verdict;

    typedef struct {
        t_item    geom;
        t_verdict verdict;
    } t_probe_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // shadow copy of the register file, updated on each accepted write
    logic signed [COORD_W-1:0] frame_off [NUM_AXES];
    logic [MARGIN_W-1:0]       margin_raw;

    bit          pending_overlap [$];
    t_probe_row  probe_table [PROBE_ROWS];
    int          idle_pct;
    int          items_fed;
    int          results_seen;
    int          hits_seen;
    int          mismatches;

    segment_aabb_overlap_test_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: exact separating-axis test in doubled coordinates.
    // mid = twice the segment midpoint minus twice the box center,
    // dir = finish - start, pad = |dir| + 2*margin. Widths leave headroom
    // so no product or sum wraps.
    // ------------------------------------------------------------------
    function automatic logic signed [39:0] mag40(logic signed [39:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit segment_hits_box(t_item it);
        logic signed [39:0] mid [NUM_AXES];
        logic signed [39:0] dir [NUM_AXES];
        logic signed [39:0] ext [NUM_AXES];
        logic signed [39:0] pad [NUM_AXES];
        logic signed [95:0] cross_gap;
        logic signed [95:0] reach;
        int k, i, j;
        for (k = 0; k < NUM_AXES; k++) begin
            ext[k] = $signed({9'b0, it.extent[k]});
            mid[k] = $signed(it.start[k]) + $signed(it.finish[k])
                   - 2 * frame_off[k] - 2 * $signed(it.corner[k]) - ext[k];
            dir[k] = $signed(it.finish[k]) - $signed(it.start[k]);
            // world axis: strictly beyond the combined radius separates
            if (mag40(mid[k]) > ext[k] + mag40(dir[k]))
                return 1'b0;
        end
        for (k = 0; k < NUM_AXES; k++)
            pad[k] = mag40(dir[k]) + 2 * $signed({1'b0, margin_raw});
        // cross axes pair (y,z), (z,x), (x,y)
        for (k = 0; k < NUM_AXES; k++) begin
            i = (k + 1) % NUM_AXES;
            j = (k + 2) % NUM_AXES;
            cross_gap = mid[i] * dir[j] - mid[j] * dir[i];
            if (cross_gap < 0)
                cross_gap = -cross_gap;
            reach = ext[i] * pad[j] + ext[j] * pad[i];
            if (cross_gap > reach)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_item seg_box(int sx, int sy, int sz, int fx, int fy, int fz,
                                      int cx, int cy, int cz, int ex, int ey, int ez);
        t_item it;
        it.start[0]  = sx;  it.start[1]  = sy;  it.start[2]  = sz;
        it.finish[0] = fx;  it.finish[1] = fy;  it.finish[2] = fz;
        it.corner[0] = cx;  it.corner[1] = cy;  it.corner[2] = cz;
        it.extent[0] = ex[EXT_W-1:0];
        it.extent[1] = ey[EXT_W-1:0];
        it.extent[2] = ez[EXT_W-1:0];
        return it;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > I32_MAX)
            return 32'h7FFF_FFFF;
        if (v < I32_MIN)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint rand_span(longint lo, longint hi);
        longint unsigned r;
        r = {$urandom, $urandom};
        return lo + longint'(r % longint'(hi - lo + 1));
    endfunction

    // Build one random item. Most items place the segment around the box so the
    // cross-axis tests get exercised; some pin endpoints onto faces and corners;
    // the rest is raw noise over every bit.
    function automatic t_item make_item();
        t_item       it;
        int          mode, sh, k;
        longint      mask, ext, wc, span, s, f;
        logic [31:0] corner;
        mode = $urandom_range(0, 99);
        sh   = $urandom_range(0, 31);
        mask = (longint'(1) << sh) - 1;
        for (k = 0; k < NUM_AXES; k++) begin
            if (mode < 12) begin
                it.start[k]  = $urandom;
                it.finish[k] = $urandom;
                it.corner[k] = $urandom;
                it.extent[k] = 31'($urandom);
            end else begin
                ext    = longint'($urandom) & mask;
                corner = clamp32(longint'($signed(32'($urandom))) - longint'(frame_off[k]));
                wc     = longint'(frame_off[k]) + longint'($signed(corner));
                span   = ext + longint'($urandom_range(0, 4));
                if (mode < 35) begin
                    // land on a face, just off it, or inside
                    case ($urandom_range(0, 4))
                        0:       s = wc - 1;
                        1:       s = wc;
                        2:       s = wc + ext;
                        3:       s = wc + ext + 1;
                        default: s = rand_span(wc, wc + ext);
                    endcase
                    f = ($urandom_range(0, 1) != 0) ? s : rand_span(wc - span, wc + ext + span);
                end else begin
                    s = rand_span(wc - span, wc + ext + span);
                    f = rand_span(wc - span, wc + ext + span);
                end
                it.start[k]  = clamp32(s);
                it.finish[k] = clamp32(f);
                it.corner[k] = corner;
                it.extent[k] = ext[EXT_W-1:0];
            end
        end
        return it;
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return $urandom;
            default: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [MARGIN_W-1:0] pick_margin();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    // Write one register and hold valid high; the caller drops valid after the batch.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_OFFSET_X: frame_off[0] = value;
            CFG_OFFSET_Y: frame_off[1] = value;
            CFG_OFFSET_Z: frame_off[2] = value;
            CFG_MARGIN:   margin_raw   = value[MARGIN_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one item, with random gaps ahead of it, and log its expected flag
    // at the edge it is taken.
    task automatic send_item(t_item it, t_verdict verdict);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(S_TDATA_W - $bits(t_item)){1'b0}}, it};
        do @(posedge i_clk); while (!o_s_axis_tready);
        case (verdict)
            ROW_SEPARATE: pending_overlap.push_back(1'b0);
            ROW_OVERLAP:  pending_overlap.push_back(1'b1);
            default:      pending_overlap.push_back(segment_hits_box(it));
        endcase
        items_fed++;
    endtask

    // Drop valid and hold until every outstanding result is back.
    task automatic hold_until_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_overlap.size() != 0);
    endtask

    function automatic void log_mismatch(string what, logic [7:0] want, logic [7:0] got);
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN)
            $display("mismatch: %s, expected %02h, actual %02h", what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure, compare each taken result against
    // the oldest expectation (overlap in bit 0, pad bits must be zero).
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        logic want;
        i_m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_overlap.size() == 0) begin
                log_mismatch("result with nothing outstanding", 8'hxx, o_m_axis_tdata);
            end else begin
                want = pending_overlap.pop_front();
                if (o_m_axis_tdata !== {7'b0, want})
                    log_mismatch("overlap", {7'b0, want}, o_m_axis_tdata);
                if (o_m_axis_tdata[0] === 1'b1)
                    hits_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, probe table under reset defaults, then several
    // register settings with random items, extremes first.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0]         off_x, off_y, off_z;
        logic [MARGIN_W-1:0] margin;
        int                  n, ph;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_OFFSET_X;
        i_cfg_data      <= '0;
        idle_pct        = IDLE_PCT;
        items_fed       = 0;
        results_seen    = 0;
        hits_seen       = 0;
        mismatches      = 0;
        for (n = 0; n < NUM_AXES; n++)
            frame_off[n] = '0;
        margin_raw = MARGIN_RESET;

        // segment endpoints, box corner, box size
        probe_table[0]  = '{seg_box(-ONE, HALF, HALF, 2*ONE, HALF, HALF,
                                    0, 0, 0, ONE, ONE, ONE), ROW_OVERLAP};
        probe_table[1]  = '{seg_box(5*ONE, 5*ONE, 5*ONE, 6*ONE, 6*ONE, 6*ONE,
                                    0, 0, 0, ONE, ONE, ONE), ROW_SEPARATE};
        // degenerate segments: a single point inside, outside, on a corner, one lsb off
        probe_table[2]  = '{seg_box(HALF, HALF, HALF, HALF, HALF, HALF,
                                    0, 0, 0, ONE, ONE, ONE), ROW_OVERLAP};
        probe_table[3]  = '{seg_box(3*ONE, HALF, HALF, 3*ONE, HALF, HALF,
                                    0, 0, 0, ONE, ONE, ONE), ROW_SEPARATE};
        probe_table[4]  = '{seg_box(ONE, ONE, ONE, ONE, ONE, ONE,
                                    0, 0, 0, ONE, ONE, ONE), ROW_OVERLAP};
        probe_table[5]  = '{seg_box(ONE + 1, HALF, HALF, ONE + 1, HALF, HALF,
                                    0, 0, 0, ONE, ONE, ONE), ROW_SEPARATE};
        // flat boxes
        probe_table[6]  = '{seg_box(ONE, ONE, ONE, ONE, ONE, ONE,
                                    ONE, ONE, ONE, 0, 0, 0), ROW_OVERLAP};
        probe_table[7]  = '{seg_box(-ONE, 0, 0, ONE, 0, 0,
                                    0, 0, 0, 0, 0, 0), ROW_OVERLAP};
        // diagonal past the corner, and grazing it: only the cross axes decide
        probe_table[8]  = '{seg_box(5*HALF, 0, HALF, 0, 5*HALF, HALF,
                                    0, 0, 0, ONE, ONE, ONE), ROW_PREDICT};
        probe_table[9]  = '{seg_box(2*ONE, 0, HALF, 0, 2*ONE, HALF,
                                    0, 0, 0, ONE, ONE, ONE), ROW_PREDICT};
        probe_table[10] = '{seg_box(-ONE, ONE, HALF, 2*ONE, ONE, HALF,
                                    0, 0, 0, ONE, ONE, ONE), ROW_PREDICT};
        // field extremes, then small and bit-pattern cases
        probe_table[11] = '{seg_box(I32_LO, I32_LO, I32_LO, I32_HI, I32_HI, I32_HI,
                                    I32_LO, I32_LO, I32_LO, EXT_HI, EXT_HI, EXT_HI),
                            ROW_PREDICT};
        probe_table[12] = '{seg_box(I32_HI, I32_HI, I32_HI, I32_HI, I32_HI, I32_HI,
                                    I32_LO, I32_LO, I32_LO, 0, 0, 0), ROW_SEPARATE};
        probe_table[13] = '{seg_box(I32_LO, I32_LO, I32_LO, I32_LO, I32_LO, I32_LO,
                                    I32_LO, I32_LO, I32_LO, 0, 0, 0), ROW_OVERLAP};
        probe_table[14] = '{seg_box(I32_HI, I32_HI, I32_HI, I32_LO, I32_LO, I32_LO,
                                    I32_LO, I32_LO, I32_LO, EXT_HI, EXT_HI, EXT_HI),
                            ROW_PREDICT};
        probe_table[15] = '{seg_box(-3*ONE, -3*ONE, -3*ONE, 0, 0, 0,
                                    -2*ONE, -2*ONE, -2*ONE, ONE, ONE, ONE), ROW_OVERLAP};
        probe_table[16] = '{seg_box(-3*ONE, HALF, HALF, -ONE, HALF, HALF,
                                    0, 0, 0, ONE, ONE, ONE), ROW_SEPARATE};
        probe_table[17] = '{seg_box(32'h5555_5555, 32'hAAAA_AAAA, 0,
                                    32'hAAAA_AAAA, 32'h5555_5555, -1,
                                    32'hCCCC_CCCC, 32'h3333_3333, 32'h0F0F_0F0F,
                                    32'h5555_5555, 32'h2AAA_AAAA, EXT_HI), ROW_PREDICT};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the probe table with the reset register values
        for (n = 0; n < PROBE_ROWS; n++)
            send_item(probe_table[n].geom, probe_table[n].verdict);
        hold_until_drained();

        for (ph = 0; ph < SETTINGS_COUNT; ph++) begin
            // pick this setting; the first two pin the register extremes
            case (ph)
                0: begin
                    off_x = 32'h8000_0000; off_y = 32'h7FFF_FFFF; off_z = 32'h0;
                    margin = '0;
                end
                1: begin
                    off_x = 32'h7FFF_FFFF; off_y = 32'h8000_0000; off_z = $urandom;
                    margin = 16'hFFFF;
                end
                default: begin
                    off_x = pick_offset(); off_y = pick_offset(); off_z = pick_offset();
                    margin = pick_margin();
                end
            endcase
            // pipeline is empty here; upper margin bits carry junk that must be dropped
            write_reg(CFG_OFFSET_X, off_x);
            write_reg(CFG_OFFSET_Y, off_y);
            write_reg(CFG_OFFSET_Z, off_z);
            write_reg(CFG_MARGIN, {16'($urandom), margin});
            i_cfg_valid <= 1'b0;

            // one setting runs with both sides flat out
            idle_pct = (ph == 2) ? 0 : IDLE_PCT;
            for (n = 0; n < ITEMS_PER_SETTING; n++) begin
                send_item(make_item(), ROW_PREDICT);
                // mid-run pause: let the pipeline empty completely
                if (ph == 3 && n == ITEMS_PER_SETTING / 2)
                    hold_until_drained();
            end
            hold_until_drained();
        end

        // let any stray result show up before judging
        idle_pct = IDLE_PCT;
        repeat (PIPE_LATENCY * 4) @(posedge i_clk);
        if (pending_overlap.size() != 0)
            mismatches += pending_overlap.size();

        $display("covered %0d items (%0d table rows) over %0d register settings",
                 items_fed, PROBE_ROWS, SETTINGS_COUNT + 1);
        $display("checked %0d results, %0d overlaps, %0d mismatches",
                 results_seen, hits_seen, mismatches);
        if (mismatches == 0)
            $display("segment_aabb_overlap_test_core regression: pass");
        else
            $display("segment_aabb_overlap_test_core regression: fail");
        $finish;
    end

    // hard stop if the handshakes ever hang
    initial begin : watchdog
        #(2 * RUN_LIMIT_CYCLES);
        $display("timeout after %0d cycles", RUN_LIMIT_CYCLES);
        $display("segment_aabb_overlap_test_core regression: fail");
        $finish;
    end

endmodule
